// ===== src/lsu_pkg.sv =====
// Shared types and constants for the literal string unescaper.
// No dependencies; used by every module in src/ except lsu_checker.
package lsu_pkg;

  // Width of the parenthesis nesting counter.
  localparam int DEPTH_BITS = 8;
  localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {DEPTH_BITS{1'b1}};

  // Character codes.
  localparam logic [7:0] CH_OPEN   = 8'h28;
  localparam logic [7:0] CH_CLOSE  = 8'h29;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DIG0   = 8'h30;
  localparam logic [7:0] CH_DIG7   = 8'h37;
  localparam logic [7:0] CH_DIG9   = 8'h39;
  localparam logic [2:0] OCT_MASK  = 3'h7;
  localparam logic [1:0] OCT_LAST  = 2'd2;

  // Front-to-back queue geometry (depth must be a power of two).
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // One queue entry: the one or two results caused by a single input byte.
  // The second result, when present, is always a plain data byte.
  typedef struct packed {
    logic [7:0] first_byte;
    logic       first_valid;
    logic       first_end;
    logic       has_second;
    logic [7:0] second_byte;
  } entry_t;

endpackage

// ===== src/lsu_front.sv =====
// Front end: classifies each accepted byte, keeps the escape/octal/depth
// state and produces one queue entry per byte that yields results. Uses lsu_pkg.
module lsu_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [7:0]           in_byte,
  input  logic                 end_of_data,
  output logic                 q_push,
  output lsu_pkg::entry_t      q_entry
);

  logic                            escape_pending;
  logic                            octal_active;
  logic [1:0]                      octal_digits;
  logic [7:0]                      octal_value;
  logic [lsu_pkg::DEPTH_BITS-1:0]  paren_depth;

  logic is_dec;
  logic is_oct;
  logic ends;
  logic octal_now;
  logic flush;
  logic escape_next;
  logic octal_after;
  logic emit_c;

  always_comb begin
    is_dec = in_byte inside {[lsu_pkg::CH_DIG0:lsu_pkg::CH_DIG9]};
    is_oct = in_byte inside {[lsu_pkg::CH_DIG0:lsu_pkg::CH_DIG7]};
    ends = end_of_data ||
           (!escape_pending && (paren_depth == '0) && (in_byte == lsu_pkg::CH_CLOSE));
    octal_now   = octal_active || (escape_pending && is_dec);
    flush       = octal_now && (!is_oct || (octal_digits > lsu_pkg::OCT_LAST));
    escape_next = (in_byte == lsu_pkg::CH_BSLASH) && !escape_pending;
    octal_after = octal_now && !flush;
    emit_c      = !escape_next && !octal_after;
  end

  always_comb begin
    q_entry = '0;
    q_entry.second_byte = in_byte;
    if (ends) begin
      q_entry.first_byte  = octal_active ? octal_value : 8'h00;
      q_entry.first_valid = octal_active;
      q_entry.first_end   = 1'b1;
    end else if (flush) begin
      q_entry.first_byte  = octal_value;
      q_entry.first_valid = 1'b1;
      q_entry.has_second  = emit_c;
    end else begin
      q_entry.first_byte  = in_byte;
      q_entry.first_valid = 1'b1;
    end
    q_push = accept && (ends || flush || emit_c);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_pending <= 1'b0;
      octal_active   <= 1'b0;
      octal_digits   <= '0;
      octal_value    <= '0;
      paren_depth    <= '0;
    end else if (accept) begin
      if (ends) begin
        escape_pending <= 1'b0;
        octal_active   <= 1'b0;
        octal_digits   <= '0;
        octal_value    <= '0;
        paren_depth    <= '0;
      end else begin
        if (!escape_pending) begin
          if (in_byte == lsu_pkg::CH_OPEN) begin
            if (paren_depth != lsu_pkg::DEPTH_MAX) begin
              paren_depth <= paren_depth + 1'b1;
            end
          end else if (in_byte == lsu_pkg::CH_CLOSE) begin
            paren_depth <= paren_depth - 1'b1;
          end
        end
        escape_pending <= escape_next;
        octal_active   <= octal_after;
        if (flush) begin
          octal_digits <= '0;
          octal_value  <= '0;
        end else if (octal_after) begin
          octal_digits <= octal_digits + 1'b1;
          octal_value  <= {octal_value[4:0], in_byte[2:0] & lsu_pkg::OCT_MASK};
        end
      end
    end
  end

endmodule

// ===== src/lsu_queue.sv =====
// Small FIFO of result entries between front and back ends.
// Depends on lsu_pkg for entry_t and the queue depth.
module lsu_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  lsu_pkg::entry_t      wr_entry,
  input  logic                 pop,
  output lsu_pkg::entry_t      rd_entry,
  output logic                 full,
  output logic                 empty
);

  lsu_pkg::entry_t                  slots [lsu_pkg::QUEUE_DEPTH];
  logic [lsu_pkg::QUEUE_AW-1:0]     wr_ptr;
  logic [lsu_pkg::QUEUE_AW-1:0]     rd_ptr;
  logic [lsu_pkg::QUEUE_AW:0]       count;
  logic                             do_push;
  logic                             do_pop;

  assign full     = (count == (lsu_pkg::QUEUE_AW + 1)'(lsu_pkg::QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign rd_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== src/lsu_back.sv =====
// Back end: splits queue entries into single results and holds the
// oldest one in the output register. Depends on lsu_pkg.
module lsu_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_empty,
  input  lsu_pkg::entry_t      q_entry,
  output logic                 q_pop,
  input  logic                 pop,
  output logic                 empty,
  output logic [7:0]           out_byte,
  output logic                 byte_valid,
  output logic                 string_end
);

  logic       out_full;
  logic       second_pending;
  logic [7:0] second_byte;
  logic       load;

  // Output slot frees up when empty or when its transaction completes.
  assign load  = !out_full || pop;
  assign q_pop = load && !second_pending && !q_empty;
  assign empty = !out_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full       <= 1'b0;
      second_pending <= 1'b0;
    end else if (load) begin
      if (second_pending) begin
        out_full       <= 1'b1;
        second_pending <= 1'b0;
      end else if (!q_empty) begin
        out_full       <= 1'b1;
        second_pending <= q_entry.has_second;
      end else begin
        out_full <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (second_pending) begin
        out_byte   <= second_byte;
        byte_valid <= 1'b1;
        string_end <= 1'b0;
      end else if (!q_empty) begin
        out_byte    <= q_entry.first_byte;
        byte_valid  <= q_entry.first_valid;
        string_end  <= q_entry.first_end;
        second_byte <= q_entry.second_byte;
      end
    end
  end

endmodule

// ===== src/literal_string_unescape.sv =====
// Top level of the literal string unescaper: front end, entry queue, back end.
// Depends on lsu_pkg, lsu_front, lsu_queue and lsu_back.
//
//  channel  | handshake          | payload                           | transaction when
//  ---------+--------------------+-----------------------------------+-----------------------
//  input    | push / full        | in_byte[7:0], end_of_data         | push && !full
//  result   | empty / pop        | out_byte[7:0], byte_valid,        | pop && !empty
//           |                    | string_end                        |
//
// One input byte is taken per cycle while full is low; the front end updates its
// state in the cycle of the transaction and writes at most one queue entry.
// The output register issues one result per cycle while pop keeps up, so a byte
// that causes two results (octal flush, then the byte that ended the octal run)
// is issued as two separate results. A 4-entry queue between front and back
// absorbs those and output stalls; full rises only when it fills. A result
// reaches the ports by a queue write, then an output register load.
// Synchronous reset; no clearing pass.
module literal_string_unescape (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       end_of_data,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic       string_end
);

  logic            accept;
  logic            q_push;
  lsu_pkg::entry_t q_wr_entry;
  lsu_pkg::entry_t q_rd_entry;
  logic            q_pop;
  logic            q_empty;

  // Input transaction: accepted bytes always update the parse state.
  assign accept = push && !full;

  // Classification and parse state (escape, octal collection, nesting depth).
  lsu_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .in_byte     (in_byte),
    .end_of_data (end_of_data),
    .q_push      (q_push),
    .q_entry     (q_wr_entry)
  );

  // Decoupling queue; bytes that yield no result (a backslash, a collected
  // octal digit) never occupy an entry.
  lsu_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wr_entry (q_wr_entry),
    .pop      (q_pop),
    .rd_entry (q_rd_entry),
    .full     (full),
    .empty    (q_empty)
  );

  // Result sequencing and output register.
  lsu_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_entry    (q_rd_entry),
    .q_pop      (q_pop),
    .pop        (pop),
    .empty      (empty),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .string_end (string_end)
  );

endmodule

// ===== src/lsu_checker.sv =====
// Port-level checks for the literal string unescaper, bound to the top level.
// No package dependencies.
module lsu_checker (
  input logic       clk,
  input logic       rst,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte,
  input logic       byte_valid,
  input logic       string_end
);

  // A waiting result stays until its transaction completes.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty)
    else $error("result dropped without a transaction");

  // A result that carries no byte can only be the end marker.
  a_marker_end: assert property (@(posedge clk) disable iff (rst)
    !empty && !byte_valid |-> string_end)
    else $error("non-byte result without string_end");

  // An end marker without data carries a zero byte.
  a_marker_zero: assert property (@(posedge clk) disable iff (rst)
    !empty && !byte_valid |-> out_byte == 8'h00)
    else $error("non-byte result with nonzero out_byte");

  // Reset leaves both sides idle.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> empty && !full)
    else $error("not idle after reset");

endmodule

bind literal_string_unescape lsu_checker u_lsu_checker (
  .clk        (clk),
  .rst        (rst),
  .full       (full),
  .empty      (empty),
  .pop        (pop),
  .out_byte   (out_byte),
  .byte_valid (byte_valid),
  .string_end (string_end)
);
